### sv/bus_arbiter_priority_alternating_top_defines.svh
// Assertion macros for the bus arbiter port-level checks.
`ifndef BUS_ARBITER_PRIORITY_ALTERNATING_TOP_DEFINES_SVH
`define BUS_ARBITER_PRIORITY_ALTERNATING_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define BAP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BAP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/bap_pkg.sv
// Types and constants for the bus arbiter.
`default_nettype none
package bap_pkg;

   typedef enum logic [1:0] {
      OP_QUERY  = 2'd0,
      OP_OFFER  = 2'd1,
      OP_COMMIT = 2'd2
   } op_type;

   localparam logic [1:0] MASTER_DMA   = 2'd0;
   localparam logic [1:0] MASTER_CPU_A = 2'd1;
   localparam logic [1:0] MASTER_CPU_B = 2'd2;

   localparam logic [7:0] CSR_REPEAT_PENALTY = 8'd0;
   localparam logic [7:0] CSR_TIE_PENALTY    = 8'd1;

   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 104;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic        pad;
      logic [15:0] service_ticks;
      logic        had_tie;
      logic [2:0]  access_size;
      logic        write_access;
      logic [31:0] address;
      logic [1:0]  master;
      logic [63:0] tick;
   } req_type;

   // result payload, must_wait in bit 0
   typedef struct packed {
      logic [63:0] free_tick;
      logic [3:0]  winner_index;
      logic [31:0] wait_ticks;
      logic        must_wait;
   } rsp_type;

   // candidate request as seen by the priority compare
   typedef struct packed {
      logic [1:0]  master;
      logic [31:0] addr;
      logic        write_access;
      logic [2:0]  size;
   } cand_type;

   // which CPU was granted last
   typedef struct packed {
      logic valid;
      logic is_b;
   } cpu_hist_type;

endpackage
`default_nettype wire

### sv/bus_arbiter_priority_alternating_top.sv
// Top level of the bus arbiter: query, offer and commit over one item stream.
// A result is registered in the result buffer before it appears on rsp_tvalid.
// Throughput: one item per cycle while req_tready is high; bus state and group state update in the accept cycle.
// A two-entry result buffer keeps req_tready high while one result waits on rsp_tready.
// Offer items other than the last of a group produce no result.
// Reset (synchronous, active high) clears bus timing, CPU history, group and penalties.
`default_nettype none
module bus_arbiter_priority_alternating_top #(
   parameter int MAX_CANDIDATES = 16,
   parameter int ADDR_WIDTH     = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tick[63:0], master[65:64], address[97:66], write_access[98], access_size[101:99],
   // had_tie[102], service_ticks[118:103], zero pad[119]
   input  logic [bap_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op[1:0]
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // must_wait[0], wait_ticks[32:1], winner_index[36:33], free_tick[100:37],
   // zero pad[103:101]
   output logic [bap_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [7:0]                        csr_index,
   input  logic [15:0]                       csr_data
);
   import bap_pkg::*;

   localparam int AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int IW = $clog2(MAX_CANDIDATES);

   // configuration
   logic [15:0] rep_pen_ff;
   logic [15:0] tie_pen_ff;

   // bus timing and history
   logic [63:0]  bus_free_ff, bus_free_in;
   logic         prev_addr_valid_ff, prev_addr_valid_in;
   logic [AW-1:0] prev_addr_ff, prev_addr_in;
   cpu_hist_type hist_ff, hist_in;

   // open offer group
   logic [CW-1:0] cand_count_ff, cand_count_in;
   logic [IW-1:0] best_index_ff, best_index_in;
   logic [1:0]    best_master_ff, best_master_in;
   logic [AW-1:0] best_addr_ff, best_addr_in;
   logic          best_write_ff, best_write_in;
   logic [2:0]    best_size_ff, best_size_in;

   req_type     req;
   op_type      op;
   logic        accept;
   logic        buf_ready;
   logic        rsp_push;
   rsp_type     rsp_data;
   rsp_type     buf_out;

   cand_type    cand;
   cand_type    best;
   logic        cand_beats;
   logic [31:0] cand_addr;
   logic [31:0] best_addr_w;

   logic        busy;
   logic [63:0] diff;
   logic [63:0] start;
   logic [15:0] svc_eff;
   logic        repeat_hit;
   logic [17:0] dur;
   logic        take;
   logic [IW+3:0] idx_ext;

   assign req        = req_type'(req_tdata);
   assign op         = op_type'(req_tuser);
   assign req_tready = buf_ready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      cand_addr = '0;
      cand_addr[AW-1:0] = req.address[AW-1:0];
      best_addr_w = '0;
      best_addr_w[AW-1:0] = best_addr_ff;
   end

   assign cand = '{master: req.master, addr: cand_addr, write_access: req.write_access,
                   size: req.access_size};
   assign best = '{master: best_master_ff, addr: best_addr_w, write_access: best_write_ff,
                   size: best_size_ff};

   bap_beats u_beats (
      .cand  (cand),
      .best  (best),
      .hist  (hist_ff),
      .beats (cand_beats)
   );

   // query and commit arithmetic
   assign busy       = req.tick < bus_free_ff;
   assign diff       = bus_free_ff - req.tick;
   assign start      = busy ? bus_free_ff : req.tick;
   assign svc_eff    = (req.service_ticks == 16'd0) ? 16'd1 : req.service_ticks;
   assign repeat_hit = prev_addr_valid_ff && (cand_addr[AW-1:0] == prev_addr_ff);
   assign dur        = 18'(svc_eff) + (repeat_hit ? 18'(rep_pen_ff) : 18'd0)
                     + (req.had_tie ? 18'(tie_pen_ff) : 18'd0);

   assign take = (cand_count_ff < CW'(MAX_CANDIDATES))
              && ((cand_count_ff == '0) || cand_beats);

   always_comb begin
      bus_free_in        = bus_free_ff;
      prev_addr_valid_in = prev_addr_valid_ff;
      prev_addr_in       = prev_addr_ff;
      hist_in            = hist_ff;
      cand_count_in      = cand_count_ff;
      best_index_in      = best_index_ff;
      best_master_in     = best_master_ff;
      best_addr_in       = best_addr_ff;
      best_write_in      = best_write_ff;
      best_size_in       = best_size_ff;
      rsp_push           = 1'b0;
      rsp_data           = '0;
      idx_ext            = '0;

      if (accept) begin
         unique case (op)
            OP_QUERY: begin
               rsp_push           = 1'b1;
               rsp_data.must_wait = busy;
               if (busy) begin
                  rsp_data.wait_ticks = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
               end
               rsp_data.free_tick = bus_free_ff;
            end
            OP_OFFER: begin
               if (take) begin
                  best_index_in  = cand_count_ff[IW-1:0];
                  best_master_in = req.master;
                  best_addr_in   = cand_addr[AW-1:0];
                  best_write_in  = req.write_access;
                  best_size_in   = req.access_size;
               end
               if (cand_count_ff < CW'(MAX_CANDIDATES)) begin
                  cand_count_in = cand_count_ff + CW'(1);
               end
               if (req_tlast) begin
                  rsp_push              = 1'b1;
                  idx_ext               = (IW + 4)'(best_index_in);
                  rsp_data.winner_index = idx_ext[3:0];
                  rsp_data.free_tick    = bus_free_ff;
                  cand_count_in         = '0;
                  best_index_in         = '0;
                  best_master_in        = '0;
                  best_addr_in          = '0;
                  best_write_in         = 1'b0;
                  best_size_in          = '0;
               end
            end
            OP_COMMIT: begin
               bus_free_in        = start + 64'(dur);
               prev_addr_valid_in = 1'b1;
               prev_addr_in       = cand_addr[AW-1:0];
               if (req.master == MASTER_CPU_A || req.master == MASTER_CPU_B) begin
                  hist_in.valid = 1'b1;
                  hist_in.is_b  = req.master == MASTER_CPU_B;
               end
               rsp_push           = 1'b1;
               rsp_data.free_tick = bus_free_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_pen_ff         <= '0;
         tie_pen_ff         <= '0;
         bus_free_ff        <= '0;
         prev_addr_valid_ff <= 1'b0;
         prev_addr_ff       <= '0;
         hist_ff            <= '0;
         cand_count_ff      <= '0;
         best_index_ff      <= '0;
         best_master_ff     <= '0;
         best_addr_ff       <= '0;
         best_write_ff      <= 1'b0;
         best_size_ff       <= '0;
      end else begin
         bus_free_ff        <= bus_free_in;
         prev_addr_valid_ff <= prev_addr_valid_in;
         prev_addr_ff       <= prev_addr_in;
         hist_ff            <= hist_in;
         cand_count_ff      <= cand_count_in;
         best_index_ff      <= best_index_in;
         best_master_ff     <= best_master_in;
         best_addr_ff       <= best_addr_in;
         best_write_ff      <= best_write_in;
         best_size_ff       <= best_size_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_REPEAT_PENALTY: rep_pen_ff <= csr_data;
               CSR_TIE_PENALTY:    tie_pen_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   bap_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rsp_push),
      .in_data   (rsp_data),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_out)
   );

   assign rsp_tdata = {3'b000, buf_out};

endmodule
`default_nettype wire

### sv/bap_beats.sv
// Priority compare: does a new candidate beat the current best of the group.
`default_nettype none
module bap_beats (
   input  bap_pkg::cand_type     cand,
   input  bap_pkg::cand_type     best,
   input  bap_pkg::cpu_hist_type hist,
   output logic                  beats
);
   import bap_pkg::*;

   function automatic logic [1:0] rank_of(input logic [1:0] m);
      logic [1:0] r;
      begin
         r = 2'd0;
         if (m == MASTER_DMA) r = 2'd2;
         else if (m == MASTER_CPU_A || m == MASTER_CPU_B) r = 2'd1;
         return r;
      end
   endfunction

   logic [1:0] rank_c;
   logic [1:0] rank_b;
   logic [1:0] pref;

   assign rank_c = rank_of(cand.master);
   assign rank_b = rank_of(best.master);
   // alternate: the CPU not granted last is preferred, CPU A at first
   assign pref = !hist.valid ? MASTER_CPU_A : (hist.is_b ? MASTER_CPU_A : MASTER_CPU_B);

   always_comb begin
      if (rank_c != rank_b) begin
         beats = rank_c > rank_b;
      end else if (cand.master != best.master) begin
         beats = cand.master == pref;
      end else if (cand.addr != best.addr) begin
         beats = cand.addr < best.addr;
      end else if (cand.write_access != best.write_access) begin
         beats = cand.write_access;
      end else begin
         beats = cand.size < best.size;
      end
   end

endmodule
`default_nettype wire

### sv/bap_rsp_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module bap_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bap_pkg::rsp_type  in_data,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output bap_pkg::rsp_type  out_data
);
   import bap_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
            if (push) main_ff <= in_data;
         end
      end else if (push) begin
         skid_ff       <= in_data;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule
`default_nettype wire

### sv/bap_chk.sv
// Port-level checks for the bus arbiter, bound to the top level.
`default_nettype none
`include "bus_arbiter_priority_alternating_top_defines.svh"
module bap_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bap_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bap_pkg::*;

   `BAP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "result valid after reset")

   `BAP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `BAP_ASSERT(a_idle_no_wait, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0, "wait ticks without busy")

   `BAP_ASSERT(a_busy_has_wait, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] != 32'd0, "busy with zero wait")

endmodule

bind bus_arbiter_priority_alternating_top bap_chk u_bap_chk (.*);
`default_nettype wire

### tb/sv/bus_grant_checker.sv
// Bus arbiter checker: watches the three channels, predicts each result and compares it.
`timescale 1ns / 1ps
module bus_grant_checker #(
   parameter int MAX_CANDIDATES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [bap_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bap_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [7:0]                      csr_index,
   input  logic [15:0]                     csr_data,
   output int                              mismatch_count,
   output int                              pending_results
);
   import bap_pkg::*;

   typedef struct packed {
      logic        must_wait;
      logic [31:0] wait_ticks;
      logic [3:0]  winner;
      logic [63:0] free_tick;
   } bus_status_type;

   bus_status_type expected_status[$];

   logic [15:0]  repeat_pen;
   logic [15:0]  tie_pen;
   logic [63:0]  bus_free;
   logic         addr_seen;
   logic [31:0]  last_addr;
   cpu_hist_type cpu_hist;
   int           group_len;
   int           best_pos;
   cand_type     best;

   initial begin
      mismatch_count = 0;
      pending_results = 0;
   end

   function automatic int master_rank(logic [1:0] m);
      case (m)
         MASTER_DMA:                 return 2;
         MASTER_CPU_A, MASTER_CPU_B: return 1;
         default:                    return 0;
      endcase
   endfunction

   function automatic logic outranks(cand_type c);
      logic [1:0] favored;
      if (master_rank(c.master) != master_rank(best.master))
         return master_rank(c.master) > master_rank(best.master);
      if (c.master != best.master) begin
         // two different CPUs: the one not granted last wins, CPU A by default
         favored = MASTER_CPU_A;
         if (cpu_hist.valid)
            favored = cpu_hist.is_b ? MASTER_CPU_A : MASTER_CPU_B;
         return c.master == favored;
      end
      if (c.addr != best.addr) return c.addr < best.addr;
      if (c.write_access != best.write_access) return c.write_access;
      return c.size < best.size;
   endfunction

   task automatic predict(input logic [1:0] op, input req_type p, input logic last);
      bus_status_type r;
      cand_type       c;
      logic [63:0]    start;
      logic [63:0]    dur;
      logic [63:0]    gap;
      r = '0;
      c.master       = p.master;
      c.addr         = p.address;
      c.write_access = p.write_access;
      c.size         = p.access_size;
      case (op)
         OP_QUERY: begin
            if (p.tick < bus_free) begin
               gap = bus_free - p.tick;
               r.must_wait = 1'b1;
               r.wait_ticks = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
            end
            r.free_tick = bus_free;
            expected_status.push_back(r);
         end
         OP_OFFER: begin
            // candidates past the limit are dropped, the last marker still closes
            if (group_len < MAX_CANDIDATES) begin
               if (group_len == 0 || outranks(c)) begin
                  best = c;
                  best_pos = group_len;
               end
               group_len++;
            end
            if (last) begin
               r.winner = best_pos[3:0];
               r.free_tick = bus_free;
               expected_status.push_back(r);
               group_len = 0;
               best_pos = 0;
               best = '0;
            end
         end
         OP_COMMIT: begin
            start = (p.tick > bus_free) ? p.tick : bus_free;
            dur = (p.service_ticks == 16'd0) ? 64'd1 : {48'd0, p.service_ticks};
            if (addr_seen && p.address == last_addr) dur += {48'd0, repeat_pen};
            if (p.had_tie) dur += {48'd0, tie_pen};
            bus_free = start + dur;
            addr_seen = 1'b1;
            last_addr = p.address;
            if (p.master == MASTER_CPU_A || p.master == MASTER_CPU_B) begin
               cpu_hist.valid = 1'b1;
               cpu_hist.is_b = (p.master == MASTER_CPU_B);
            end
            r.free_tick = bus_free;
            expected_status.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      bus_status_type e;
      if (reset) begin
         repeat_pen = '0;
         tie_pen = '0;
         bus_free = '0;
         addr_seen = 1'b0;
         last_addr = '0;
         cpu_hist = '0;
         group_len = 0;
         best_pos = 0;
         best = '0;
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REPEAT_PENALTY: repeat_pen = csr_data;
               CSR_TIE_PENALTY:    tie_pen = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict(req_tuser, req_type'(req_tdata), req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               e = expected_status.pop_front();
               check_field("must_wait", 64'(e.must_wait), 64'(rsp_tdata[0]));
               check_field("wait_ticks", 64'(e.wait_ticks), 64'(rsp_tdata[32:1]));
               check_field("winner_index", 64'(e.winner), 64'(rsp_tdata[36:33]));
               check_field("free_tick", e.free_tick, rsp_tdata[100:37]);
            end
         end
      end
      pending_results = expected_status.size();
   end

endmodule

### tb/sv/testbench.sv
// Testbench top for the bus arbiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import bap_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] MASTER_NONE = 2'd3;
   localparam int         PHASE_ITEMS = 425;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [7:0]             csr_index;
   logic [15:0]            csr_data;
   int                     mismatch_count;
   int                     pending_results;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          items_sent = 0;
   logic [63:0] tick_base = 64'd0;
   logic [31:0] addr_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_1004};

   bus_arbiter_priority_alternating_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bus_grant_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      #(4_000_000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type noise_payload();
      req_type p;
      p.tick          = {$urandom, $urandom};
      p.master        = 2'($urandom);
      p.address       = $urandom;
      p.write_access  = 1'($urandom);
      p.access_size   = 3'($urandom);
      p.had_tie       = 1'($urandom);
      p.service_ticks = 16'($urandom);
      p.pad           = 1'b0;
      return p;
   endfunction

   function automatic logic [1:0] pick_master();
      int r;
      r = $urandom_range(99);
      if (r < 20) return MASTER_DMA;
      if (r < 55) return MASTER_CPU_A;
      if (r < 90) return MASTER_CPU_B;
      return MASTER_NONE;
   endfunction

   function automatic logic [31:0] pick_addr();
      if ($urandom_range(3) != 0) return addr_pool[$urandom_range(3)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_size();
      if ($urandom_range(4) != 0) return 3'($urandom_range(4, 1));
      return 3'($urandom_range(7));
   endfunction

   // valid stays high from one item to the next unless an idle gap is drawn
   task automatic send(input logic [1:0] op, input req_type p, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= p;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic query(input logic [63:0] tick);
      req_type p;
      p = noise_payload();
      p.tick = tick;
      send(OP_QUERY, p, 1'($urandom));
   endtask

   task automatic commit(input logic [63:0] tick, input logic [1:0] master,
                         input logic [31:0] addr, input logic tie, input logic [15:0] svc);
      req_type p;
      p = noise_payload();
      p.tick = tick;
      p.master = master;
      p.address = addr;
      p.had_tie = tie;
      p.service_ticks = svc;
      send(OP_COMMIT, p, 1'($urandom));
   endtask

   task automatic offer(input logic [1:0] master, input logic [31:0] addr,
                        input logic wr, input logic [2:0] size, input logic last);
      req_type p;
      p = noise_payload();
      p.master = master;
      p.address = addr;
      p.write_access = wr;
      p.access_size = size;
      send(OP_OFFER, p, last);
   endtask

   task automatic unused_op();
      send(OP_UNUSED, noise_payload(), 1'($urandom));
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_penalties(input logic [15:0] repeat_ticks, input logic [15:0] tie_ticks);
      write_reg(CSR_REPEAT_PENALTY, repeat_ticks);
      write_reg(CSR_TIE_PENALTY, tie_ticks);
      csr_valid <= 1'b0;
   endtask

   // wait for every outstanding result, then let the result pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic side_op();
      case ($urandom_range(2))
         0: query(tick_base + 64'($urandom_range(800)));
         1: commit(tick_base + 64'($urandom_range(400)), pick_master(), pick_addr(),
                   1'($urandom), 16'($urandom_range(300)));
         default: unused_op();
      endcase
   endtask

   task automatic random_traffic(input int count);
      int          goal;
      int          r;
      int          len;
      logic [63:0] t;
      goal = items_sent + count;
      while (items_sent < goal) begin
         r = $urandom_range(99);
         tick_base += 64'($urandom_range(150));
         if (r < 45) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(20, 14) : $urandom_range(6, 1);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 8) side_op();
               offer(pick_master(), pick_addr(), 1'($urandom), pick_size(), i == len - 1);
            end
         end else if (r < 70) begin
            t = tick_base + 64'($urandom_range(400));
            if ($urandom_range(99) < 3) begin
               t = {$urandom, $urandom};
               tick_base = t;
            end
            commit(t, pick_master(), pick_addr(), 1'($urandom),
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300)));
         end else if (r < 95) begin
            t = ($urandom_range(49) == 0) ? {$urandom, $urandom}
                                          : tick_base + 64'($urandom_range(800));
            query(t);
         end else begin
            unused_op();
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_penalties(16'd5, 16'd7);
      query(64'd0);
      commit(64'd100, MASTER_CPU_A, 32'h10, 1'b0, 16'd0);   // zero service clamps to one
      query(64'd50);
      query(64'd101);
      commit(64'd0, MASTER_CPU_B, 32'h10, 1'b1, 16'hFFFF);  // repeat address and tie
      commit(64'h0000_0100_0000_0000, MASTER_NONE, 32'hFFFF_FFFF, 1'b0, 16'd1);
      query(64'd0);                                         // wait saturates
      commit(64'hFFFF_FFFF_FFFF_FFFF, MASTER_DMA, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);  // wraps
      query(64'hFFFF_FFFF_FFFF_FFFF);
      // CPU B went last, so CPU A is favored
      offer(MASTER_CPU_A, 32'd5, 1'b0, 3'd4, 1'b0);
      offer(MASTER_CPU_B, 32'd5, 1'b0, 3'd4, 1'b1);
      offer(MASTER_CPU_B, 32'd3, 1'b0, 3'd1, 1'b0);
      offer(MASTER_DMA, 32'd9, 1'b0, 3'd1, 1'b0);
      offer(MASTER_CPU_A, 32'd1, 1'b0, 3'd1, 1'b1);
      // same master and address: write, then size; a query, an unused op and a commit in between
      offer(MASTER_DMA, 32'd8, 1'b0, 3'd4, 1'b0);
      offer(MASTER_DMA, 32'd8, 1'b1, 3'd4, 1'b0);
      query(64'd10);
      offer(MASTER_DMA, 32'd8, 1'b1, 3'd2, 1'b0);
      unused_op();
      commit(64'd20, MASTER_CPU_A, 32'h44, 1'b0, 16'd3);
      offer(MASTER_DMA, 32'd8, 1'b1, 3'd0, 1'b0);
      offer(MASTER_DMA, 32'd8, 1'b1, 3'd7, 1'b1);
      offer(MASTER_NONE, 32'd0, 1'b1, 3'd1, 1'b0);
      offer(MASTER_CPU_B, 32'hFFFF_FFFF, 1'b0, 3'd7, 1'b1);
      offer(MASTER_DMA, 32'd0, 1'b0, 3'd1, 1'b1);
      // overflow: winner sits at the top position, a better one past the limit is dropped
      for (int i = 0; i < 17; i++)
         offer((i >= 15) ? MASTER_DMA : MASTER_CPU_A, (i == 16) ? 32'd0 : 32'd100,
               1'b0, 3'd2, i == 16);
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0;  receiver_stall_pct = 0;
               set_penalties(16'd0, 16'd0);
            end
            1: begin
               sender_idle_pct = 60; receiver_stall_pct = 0;
               set_penalties(16'hFFFF, 16'hFFFF);
            end
            2: begin
               sender_idle_pct = 0;  receiver_stall_pct = 60;
               set_penalties(16'($urandom), 16'($urandom));
            end
            default: begin
               sender_idle_pct = 14; receiver_stall_pct = 14;
               set_penalties(16'd1, 16'($urandom_range(16'hFFFF)));
            end
         endcase
         random_traffic(PHASE_ITEMS);
         settle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/bap_pkg.sv
sv/bap_beats.sv
sv/bap_rsp_buf.sv
sv/bus_arbiter_priority_alternating_top.sv
sv/bap_chk.sv
tb/sv/bus_grant_checker.sv
tb/sv/testbench.sv
